// File: rtl/spp_pkg.sv
// shared types, constants and helpers for the sprite screen projection block
`timescale 1ns / 1ps
`default_nettype none
package spp_pkg;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 152;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_ADDR_W = 3;

	// quotient bits of the camera-space and the screen-size dividers
	localparam int CAM_QW = 24;
	localparam int SCR_QW = 16;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_CAM_POS_X     = 3'd0,
		REG_CAM_POS_Y     = 3'd1,
		REG_VIEW_DIR_X    = 3'd2,
		REG_VIEW_DIR_Y    = 3'd3,
		REG_CAM_PLANE_X   = 3'd4,
		REG_CAM_PLANE_Y   = 3'd5,
		REG_SCREEN_WIDTH  = 3'd6,
		REG_SCREEN_HEIGHT = 3'd7
	} reg_idx_t;

	localparam logic [15:0] RST_CAM_POS_X     = 16'd0;
	localparam logic [15:0] RST_CAM_POS_Y     = 16'd0;
	localparam logic [15:0] RST_VIEW_DIR_X    = 16'hC000;
	localparam logic [15:0] RST_VIEW_DIR_Y    = 16'd0;
	localparam logic [15:0] RST_CAM_PLANE_X   = 16'd0;
	localparam logic [15:0] RST_CAM_PLANE_Y   = 16'd10813;
	localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd640;
	localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd480;

	localparam logic [11:0] SCREEN_MAX = 12'd2048;

	typedef struct packed {
		logic [15:0]        cam_pos_x;
		logic [15:0]        cam_pos_y;
		logic signed [15:0] view_dir_x;
		logic signed [15:0] view_dir_y;
		logic signed [15:0] cam_plane_x;
		logic signed [15:0] cam_plane_y;
		logic [11:0]        screen_width;
		logic [11:0]        screen_height;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] last_column;
		logic [14:0]        first_column;
		logic [10:0]        last_row;
		logic [10:0]        first_row;
		logic [14:0]        proj_width;
		logic [14:0]        proj_height;
		logic signed [15:0] center_column;
		logic signed [23:0] depth;
		logic signed [23:0] lateral;
		logic               zero_depth;
	} res_t;

	// zero acts as one, anything past the largest screen as the largest screen
	function automatic logic [11:0] screen_dim(input logic [11:0] r);
		logic [11:0] v;
		v = r;
		if (r == 12'd0)
			v = 12'd1;
		else if (r > SCREEN_MAX)
			v = SCREEN_MAX;
		return v;
	endfunction

endpackage
`default_nettype wire

// File: rtl/spp_div.sv
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`timescale 1ns / 1ps
`default_nettype none
module spp_div #(
	parameter int NW = 50,
	parameter int DW = 33,
	parameter int QW = 24,
	parameter int PW = 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [PW-1:0] in_pay,
	output logic               out_valid,
	output logic [QW-1:0]      quo,
	output logic               ovf,
	output logic [PW-1:0]      out_pay
);

	localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic [QW:0]   vld_s;
	logic [QW:0]   ovf_s;
	logic [NW-1:0] rem_s [QW+1];
	logic [DW-1:0] den_s [QW+1];
	logic [QW-1:0] quo_s [QW+1];
	logic [PW-1:0] pay_s [QW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			pay_s[0] <= in_pay;
			ovf_s[0] <= (CW'(num) >= (CW'(den) << QW));
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_step
		localparam int B = QW - k;
		logic [CW-1:0] rx;
		logic [CW-1:0] dsh;
		logic          take;
		logic [QW-1:0] qn;

		always_comb begin
			rx   = CW'(rem_s[k-1]);
			dsh  = CW'(den_s[k-1]) << B;
			take = (rx >= dsh);
			qn   = quo_s[k-1];
			qn[B] = take;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? NW'(rx - dsh) : rem_s[k-1];
				den_s[k] <= den_s[k-1];
				quo_s[k] <= qn;
				pay_s[k] <= pay_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quo       = quo_s[QW];
	assign ovf       = ovf_s[QW];
	assign out_pay   = pay_s[QW];

endmodule
`default_nettype wire

// File: rtl/spp_front.sv
// camera transform front end: offsets, products, sums and magnitudes for the dividers
`timescale 1ns / 1ps
`default_nettype none
module spp_front
	import spp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire cfg_t        cfg,
	input  wire logic        in_valid,
	input  wire logic [15:0] sprite_pos_x,
	input  wire logic [15:0] sprite_pos_y,
	output logic             valid_s4,
	output logic [49:0]      lat_num_s4,
	output logic [49:0]      dep_num_s4,
	output logic [32:0]      det_mag_s4,
	output logic             lat_neg_s4,
	output logic             dep_neg_s4,
	output logic             det_zero_s4
);

	logic               valid_s1, valid_s2, valid_s3;
	logic signed [16:0] dx_s1, dy_s1;
	logic signed [32:0] p1_s2, p2_s2, p3_s2, p4_s2;
	logic signed [31:0] d1_s2, d2_s2;
	logic signed [33:0] nx_s3, ny_s3;
	logic signed [32:0] det_s3;
	logic [33:0]        nx_mag, ny_mag;
	logic [32:0]        det_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_comb begin
		nx_mag  = nx_s3[33] ? 34'(-nx_s3) : 34'(nx_s3);
		ny_mag  = ny_s3[33] ? 34'(-ny_s3) : 34'(ny_s3);
		det_mag = det_s3[32] ? 33'(-det_s3) : 33'(det_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= $signed({1'b0, sprite_pos_x}) - $signed({1'b0, cfg.cam_pos_x});
			dy_s1 <= $signed({1'b0, sprite_pos_y}) - $signed({1'b0, cfg.cam_pos_y});

			p1_s2 <= $signed(cfg.view_dir_y) * dx_s1;
			p2_s2 <= $signed(cfg.view_dir_x) * dy_s1;
			p3_s2 <= $signed(cfg.cam_plane_x) * dy_s1;
			p4_s2 <= $signed(cfg.cam_plane_y) * dx_s1;
			d1_s2 <= $signed(cfg.cam_plane_x) * $signed(cfg.view_dir_y);
			d2_s2 <= $signed(cfg.cam_plane_y) * $signed(cfg.view_dir_x);

			nx_s3  <= {p1_s2[32], p1_s2} - {p2_s2[32], p2_s2};
			ny_s3  <= {p3_s2[32], p3_s2} - {p4_s2[32], p4_s2};
			det_s3 <= {d1_s2[31], d1_s2} - {d2_s2[31], d2_s2};

			// numerators carry the extra 2^16 scale of the camera transform
			lat_num_s4  <= {nx_mag, 16'd0};
			dep_num_s4  <= {ny_mag, 16'd0};
			det_mag_s4  <= det_mag;
			lat_neg_s4  <= nx_s3[33] ^ det_s3[32];
			dep_neg_s4  <= ny_s3[33] ^ det_s3[32];
			det_zero_s4 <= (det_s3 == 33'sd0);
		end
	end

endmodule
`default_nettype wire

// File: rtl/spp_clip.sv
// draw rectangle clamping and output register
`timescale 1ns / 1ps
`default_nettype none
module spp_clip
	import spp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic [11:0]        width,
	input  wire logic [11:0]        height,
	input  wire logic signed [23:0] lat,
	input  wire logic signed [23:0] dep,
	input  wire logic               zd,
	input  wire logic signed [15:0] cc,
	input  wire logic [14:0]        ph,
	input  wire logic [14:0]        pw,
	output logic                    valid_s9,
	output res_t                    res_s9
);

	logic [10:0]        half_h;
	logic [13:0]        half_ph, half_pw;
	logic signed [15:0] fr_t;
	logic [14:0]        lr_t;
	logic signed [16:0] fc_t, lc_t;
	res_t               res;

	always_comb begin
		half_h  = height[11:1];
		half_ph = ph[14:1];
		half_pw = pw[14:1];
		fr_t    = $signed({5'd0, half_h}) - $signed({2'd0, half_ph});
		lr_t    = 15'(half_ph) + 15'(half_h);
		fc_t    = {cc[15], cc} - $signed({3'd0, half_pw});
		lc_t    = {cc[15], cc} + $signed({3'd0, half_pw});

		res.lateral       = lat;
		res.depth         = dep;
		res.zero_depth    = zd;
		res.center_column = cc;
		res.proj_height   = ph;
		res.proj_width    = pw;
		res.first_row     = fr_t[15] ? 11'd0 : fr_t[10:0];
		res.last_row      = (lr_t >= 15'(height)) ? 11'(height - 12'd1) : lr_t[10:0];
		res.first_column  = fc_t[16] ? 15'd0 : fc_t[14:0];
		res.last_column   = (lc_t >= $signed({5'd0, width})) ?
			$signed(16'(width - 12'd1)) : lc_t[15:0];
		if (zd) begin
			res.first_row    = '0;
			res.last_row     = '0;
			res.first_column = '0;
			res.last_column  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else if (en) begin
			valid_s9 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s9 <= res;
		end
	end

endmodule
`default_nettype wire

// File: rtl/sprite_screen_projection.sv
// stages in order: s1-s4, camera-space dividers, s5-s7, screen-size dividers, s8, s9
// one sprite per cycle unless stalled; two chains of one-bit-per-stage dividers set depth
// a stalled output holds the whole pipeline in place, nothing is dropped or repeated
// reset: arst_n clears all valid bits and loads the camera and screen registers
// with their default values
`timescale 1ns / 1ps
`default_nettype none
module sprite_screen_projection
	import spp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// sprite_pos_x, sprite_pos_y
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// lateral, depth, center_column, proj_height, proj_width, first_row, last_row,
	// first_column, last_column, zero pad
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// zero_depth
	output logic                       m_axis_tuser
);

	cfg_t cfg_q;
	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cam_pos_x     <= RST_CAM_POS_X;
			cfg_q.cam_pos_y     <= RST_CAM_POS_Y;
			cfg_q.view_dir_x    <= RST_VIEW_DIR_X;
			cfg_q.view_dir_y    <= RST_VIEW_DIR_Y;
			cfg_q.cam_plane_x   <= RST_CAM_PLANE_X;
			cfg_q.cam_plane_y   <= RST_CAM_PLANE_Y;
			cfg_q.screen_width  <= RST_SCREEN_WIDTH;
			cfg_q.screen_height <= RST_SCREEN_HEIGHT;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_addr))
				REG_CAM_POS_X:     cfg_q.cam_pos_x     <= cfg_wdata;
				REG_CAM_POS_Y:     cfg_q.cam_pos_y     <= cfg_wdata;
				REG_VIEW_DIR_X:    cfg_q.view_dir_x    <= cfg_wdata;
				REG_VIEW_DIR_Y:    cfg_q.view_dir_y    <= cfg_wdata;
				REG_CAM_PLANE_X:   cfg_q.cam_plane_x   <= cfg_wdata;
				REG_CAM_PLANE_Y:   cfg_q.cam_plane_y   <= cfg_wdata;
				REG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_wdata[11:0];
				REG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	logic [11:0] scr_w, scr_h;
	assign scr_w = screen_dim(cfg_q.screen_width);
	assign scr_h = screen_dim(cfg_q.screen_height);

	logic valid_s9;
	res_t res_s9;

	assign en            = !valid_s9 || m_axis_tready;
	assign s_axis_tready = en;

	// camera transform front end
	logic        valid_s4;
	logic [49:0] lat_num_s4, dep_num_s4;
	logic [32:0] det_mag_s4;
	logic        lat_neg_s4, dep_neg_s4, det_zero_s4;

	spp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.cfg          (cfg_q),
		.in_valid     (s_axis_tvalid),
		.sprite_pos_x (s_axis_tdata[15:0]),
		.sprite_pos_y (s_axis_tdata[31:16]),
		.valid_s4     (valid_s4),
		.lat_num_s4   (lat_num_s4),
		.dep_num_s4   (dep_num_s4),
		.det_mag_s4   (det_mag_s4),
		.lat_neg_s4   (lat_neg_s4),
		.dep_neg_s4   (dep_neg_s4),
		.det_zero_s4  (det_zero_s4)
	);

	// lateral and depth divisions by the camera determinant
	logic              lat_dv, dep_dv, lat_ovf, dep_ovf;
	logic [CAM_QW-1:0] lat_quo, dep_quo;
	logic [1:0]        lat_pay;
	logic              dep_pay;

	spp_div #(.NW(50), .DW(33), .QW(CAM_QW), .PW(2)) u_div_lat (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s4),
		.num       (lat_num_s4),
		.den       (det_mag_s4),
		.in_pay    ({det_zero_s4, lat_neg_s4}),
		.out_valid (lat_dv),
		.quo       (lat_quo),
		.ovf       (lat_ovf),
		.out_pay   (lat_pay)
	);

	spp_div #(.NW(50), .DW(33), .QW(CAM_QW), .PW(1)) u_div_dep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s4),
		.num       (dep_num_s4),
		.den       (det_mag_s4),
		.in_pay    (dep_neg_s4),
		.out_valid (dep_dv),
		.quo       (dep_quo),
		.ovf       (dep_ovf),
		.out_pay   (dep_pay)
	);

	// signed saturation of the camera coordinates
	logic signed [23:0] lat_sat, dep_sat;

	always_comb begin
		if (lat_pay[0])
			lat_sat = (lat_ovf || lat_quo > 24'h800000) ? 24'sh800000 : 24'(-lat_quo);
		else
			lat_sat = (lat_ovf || lat_quo[23]) ? 24'sh7FFFFF : lat_quo;
		if (dep_pay)
			dep_sat = (dep_ovf || dep_quo > 24'h800000) ? 24'sh800000 : 24'(-dep_quo);
		else
			dep_sat = (dep_ovf || dep_quo[23]) ? 24'sh7FFFFF : dep_quo;
		if (lat_pay[1]) begin
			lat_sat = '0;
			dep_sat = '0;
		end
	end

	logic               valid_s5, valid_s6, valid_s7;
	logic signed [23:0] lat_s5, dep_s5, lat_s6, dep_s6, lat_s7, dep_s7;
	logic               zd_s5, zd_s6, zd_s7;
	logic signed [24:0] coord_sum;
	logic signed [35:0] prod_s6;
	logic [35:0]        cc_num_s7;
	logic [23:0]        dep_mag_s7, ph_num_s7, pw_num_s7;
	logic               cc_neg_s7;

	assign coord_sum = {dep_s5[23], dep_s5} + {lat_s5[23], lat_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (en) begin
			valid_s5 <= lat_dv & dep_dv;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lat_s5 <= lat_sat;
			dep_s5 <= dep_sat;
			zd_s5  <= (dep_sat == 24'sd0);

			lat_s6  <= lat_s5;
			dep_s6  <= dep_s5;
			zd_s6   <= zd_s5;
			prod_s6 <= $signed({25'd0, scr_w[11:1]}) *
				$signed({{11{coord_sum[24]}}, coord_sum});

			lat_s7     <= lat_s6;
			dep_s7     <= dep_s6;
			zd_s7      <= zd_s6;
			cc_num_s7  <= prod_s6[35] ? 36'(-prod_s6) : 36'(prod_s6);
			cc_neg_s7  <= prod_s6[35] ^ dep_s6[23];
			dep_mag_s7 <= dep_s6[23] ? 24'(-dep_s6) : 24'(dep_s6);
			ph_num_s7  <= {scr_h, 12'd0};
			pw_num_s7  <= {scr_w, 12'd0};
		end
	end

	// center column and projected size divisions by the depth
	logic              cc_dv, ph_dv, pw_dv, cc_ovf, ph_ovf, pw_ovf;
	logic [SCR_QW-1:0] cc_quo, ph_quo, pw_quo;
	logic [47:0]       cc_pay;
	logic              ph_pay, pw_pay;

	spp_div #(.NW(36), .DW(24), .QW(SCR_QW), .PW(48)) u_div_cc (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s7),
		.num       (cc_num_s7),
		.den       (dep_mag_s7),
		.in_pay    ({dep_s7, lat_s7}),
		.out_valid (cc_dv),
		.quo       (cc_quo),
		.ovf       (cc_ovf),
		.out_pay   (cc_pay)
	);

	spp_div #(.NW(24), .DW(24), .QW(SCR_QW), .PW(1)) u_div_ph (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s7),
		.num       (ph_num_s7),
		.den       (dep_mag_s7),
		.in_pay    (zd_s7),
		.out_valid (ph_dv),
		.quo       (ph_quo),
		.ovf       (ph_ovf),
		.out_pay   (ph_pay)
	);

	spp_div #(.NW(24), .DW(24), .QW(SCR_QW), .PW(1)) u_div_pw (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s7),
		.num       (pw_num_s7),
		.den       (dep_mag_s7),
		.in_pay    (cc_neg_s7),
		.out_valid (pw_dv),
		.quo       (pw_quo),
		.ovf       (pw_ovf),
		.out_pay   (pw_pay)
	);

	logic               valid_s8, zd_s8;
	logic signed [23:0] lat_s8, dep_s8;
	logic signed [15:0] cc_s8, cc_sat;
	logic [14:0]        ph_s8, pw_s8, ph_sat, pw_sat;

	always_comb begin
		if (pw_pay)
			cc_sat = (cc_ovf || cc_quo > 16'h8000) ? 16'sh8000 : 16'(-cc_quo);
		else
			cc_sat = (cc_ovf || cc_quo[15]) ? 16'sh7FFF : cc_quo;
		ph_sat = (ph_ovf || ph_quo[15]) ? 15'h7FFF : ph_quo[14:0];
		pw_sat = (pw_ovf || pw_quo[15]) ? 15'h7FFF : pw_quo[14:0];
		if (ph_pay) begin
			cc_sat = '0;
			ph_sat = '0;
			pw_sat = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else if (en) begin
			valid_s8 <= cc_dv & ph_dv & pw_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lat_s8 <= cc_pay[23:0];
			dep_s8 <= cc_pay[47:24];
			zd_s8  <= ph_pay;
			cc_s8  <= cc_sat;
			ph_s8  <= ph_sat;
			pw_s8  <= pw_sat;
		end
	end

	spp_clip u_clip (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid_s8),
		.width    (scr_w),
		.height   (scr_h),
		.lat      (lat_s8),
		.dep      (dep_s8),
		.zd       (zd_s8),
		.cc       (cc_s8),
		.ph       (ph_s8),
		.pw       (pw_s8),
		.valid_s9 (valid_s9),
		.res_s9   (res_s9)
	);

	assign m_axis_tvalid = valid_s9;
	assign m_axis_tuser  = res_s9.zero_depth;
	assign m_axis_tdata  = {5'd0,
		res_s9.last_column, res_s9.first_column, res_s9.last_row, res_s9.first_row,
		res_s9.proj_width, res_s9.proj_height, res_s9.center_column,
		res_s9.depth, res_s9.lateral};

endmodule
`default_nettype wire

// File: tb/sprite_screen_projection_test.sv
// testbench for the sprite screen projection block: scoreboard, stimulus and checks
`timescale 1ns / 1ps
`default_nettype none
module sprite_screen_projection_test;
	import spp_pkg::*;

	class projection_scoreboard;
		logic [15:0] regs [8];
		res_t        pending_results [$];
		int          errors;

		function new();
			regs[REG_CAM_POS_X]     = RST_CAM_POS_X;
			regs[REG_CAM_POS_Y]     = RST_CAM_POS_Y;
			regs[REG_VIEW_DIR_X]    = RST_VIEW_DIR_X;
			regs[REG_VIEW_DIR_Y]    = RST_VIEW_DIR_Y;
			regs[REG_CAM_PLANE_X]   = RST_CAM_PLANE_X;
			regs[REG_CAM_PLANE_Y]   = RST_CAM_PLANE_Y;
			regs[REG_SCREEN_WIDTH]  = {4'd0, RST_SCREEN_WIDTH};
			regs[REG_SCREEN_HEIGHT] = {4'd0, RST_SCREEN_HEIGHT};
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [15:0] val);
			if (idx == REG_SCREEN_WIDTH || idx == REG_SCREEN_HEIGHT)
				regs[idx] = {4'd0, val[11:0]};
			else
				regs[idx] = val;
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		// computes the expected projection of one sprite
		function void note_sprite(logic [15:0] px, logic [15:0] py);
			longint dx, dy, dirx, diry, plx, ply, w, h, det, lat, dep;
			longint cc, ph, pw, fr, lr, fc, lc;
			res_t e;
			dx = longint'(px) - longint'(regs[REG_CAM_POS_X]);
			dy = longint'(py) - longint'(regs[REG_CAM_POS_Y]);
			dirx = longint'($signed(regs[REG_VIEW_DIR_X]));
			diry = longint'($signed(regs[REG_VIEW_DIR_Y]));
			plx = longint'($signed(regs[REG_CAM_PLANE_X]));
			ply = longint'($signed(regs[REG_CAM_PLANE_Y]));
			w = clamp(longint'(regs[REG_SCREEN_WIDTH][11:0]), 1, 2048);
			h = clamp(longint'(regs[REG_SCREEN_HEIGHT][11:0]), 1, 2048);
			det = plx * diry - ply * dirx;
			lat = 0; dep = 0;
			cc = 0; ph = 0; pw = 0; fr = 0; lr = 0; fc = 0; lc = 0;
			if (det != 0) begin
				lat = clamp(((diry * dx - dirx * dy) * 65536) / det, -8388608, 8388607);
				dep = clamp(((plx * dy - ply * dx) * 65536) / det, -8388608, 8388607);
			end
			if (dep != 0) begin
				cc = clamp(((w / 2) * (dep + lat)) / dep, -32768, 32767);
				ph = (h * 4096) / dep;
				if (ph < 0) ph = -ph;
				ph = clamp(ph, 0, 32767);
				pw = (w * 4096) / dep;
				if (pw < 0) pw = -pw;
				pw = clamp(pw, 0, 32767);
				fr = h / 2 - ph / 2;
				if (fr < 0) fr = 0;
				lr = ph / 2 + h / 2;
				if (lr >= h) lr = h - 1;
				fc = cc - pw / 2;
				if (fc < 0) fc = 0;
				lc = cc + pw / 2;
				if (lc >= w) lc = w - 1;
			end
			e.lateral = lat[23:0];
			e.depth = dep[23:0];
			e.zero_depth = (dep == 0);
			e.center_column = cc[15:0];
			e.proj_height = ph[14:0];
			e.proj_width = pw[14:0];
			e.first_row = fr[10:0];
			e.last_row = lr[10:0];
			e.first_column = fc[14:0];
			e.last_column = lc[15:0];
			pending_results.push_back(e);
		endfunction

		function void compare(string name, longint e, longint a);
			if (e != a) begin
				$error("%s: expected %0d, got %0d", name, e, a);
				errors++;
			end
		endfunction

		function void check_result(res_t a);
			res_t e;
			if (pending_results.size() == 0) begin
				$error("result transaction with no sprite outstanding");
				errors++;
				return;
			end
			e = pending_results.pop_front();
			compare("lateral", e.lateral, a.lateral);
			compare("depth", e.depth, a.depth);
			compare("zero_depth", e.zero_depth, a.zero_depth);
			compare("center_column", e.center_column, a.center_column);
			compare("proj_height", e.proj_height, a.proj_height);
			compare("proj_width", e.proj_width, a.proj_width);
			compare("first_row", e.first_row, a.first_row);
			compare("last_row", e.last_row, a.last_row);
			compare("first_column", e.first_column, a.first_column);
			compare("last_column", e.last_column, a.last_column);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;

	projection_scoreboard sb = new();
	int send_idle_pct = 19;
	int recv_idle_pct = 80;
	int unsigned cycles = 0;

	sprite_screen_projection dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		m_axis_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		res_t a;
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("[FAIL] regression broken");
			$finish;
		end
		if (s_axis_tvalid && s_axis_tready)
			sb.note_sprite(s_axis_tdata[15:0], s_axis_tdata[31:16]);
		if (m_axis_tvalid && m_axis_tready) begin
			a.lateral = m_axis_tdata[23:0];
			a.depth = m_axis_tdata[47:24];
			a.center_column = m_axis_tdata[63:48];
			a.proj_height = m_axis_tdata[78:64];
			a.proj_width = m_axis_tdata[93:79];
			a.first_row = m_axis_tdata[104:94];
			a.last_row = m_axis_tdata[115:105];
			a.first_column = m_axis_tdata[130:116];
			a.last_column = m_axis_tdata[146:131];
			a.zero_depth = m_axis_tuser;
			sb.check_result(a);
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic send_sprite(logic [15:0] px, logic [15:0] py);
		// each cycle idles with the sender's idle percentage
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {py, px};
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
	endtask

	task automatic camera(logic [15:0] cx, logic [15:0] cy, logic [15:0] dx, logic [15:0] dy,
			logic [15:0] plx, logic [15:0] ply, logic [15:0] w, logic [15:0] h);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		drain();
		write_reg(REG_CAM_POS_X, cx);
		write_reg(REG_CAM_POS_Y, cy);
		write_reg(REG_VIEW_DIR_X, dx);
		write_reg(REG_VIEW_DIR_Y, dy);
		write_reg(REG_CAM_PLANE_X, plx);
		write_reg(REG_CAM_PLANE_Y, ply);
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
	endtask

	function automatic logic [15:0] rand_screen();
		case ($urandom_range(9))
			0: return 16'd0;
			1: return 16'd4095;
			2: return 16'd2048;
			3: return 16'd1;
			default: return 16'($urandom_range(2048, 1));
		endcase
	endfunction

	task automatic random_camera();
		int dx, dy;
		logic [15:0] cx, cy;
		cx = 16'($urandom);
		cy = 16'($urandom);
		if ($urandom_range(9) < 7) begin
			// well-formed camera: plane perpendicular to the view direction
			dx = $urandom_range(32768) - 16384;
			dy = $urandom_range(32768) - 16384;
			if (dx == 0 && dy == 0) dx = 16384;
			camera(cx, cy, 16'(dx), 16'(dy), 16'(-dy * 2 / 3), 16'(dx * 2 / 3),
				rand_screen(), rand_screen());
		end else if ($urandom_range(1)) begin
			camera(cx, cy, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				rand_screen(), rand_screen());
		end else begin
			camera(cx, cy, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
				rand_screen(), rand_screen());
		end
	endtask

	initial begin
		logic [15:0] px, py;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset camera: sprite on the camera, corners of the map and other points near the camera
		send_sprite(16'd0, 16'd0);
		send_sprite(16'hFFFF, 16'hFFFF);
		send_sprite(16'hFFFF, 16'd0);
		send_sprite(16'd0, 16'hFFFF);
		send_sprite(16'd0, 16'd1024);
		send_sprite(16'd2048, 16'd512);
		send_sprite(16'd1, 16'd0);
		// degenerate camera: zero determinant
		camera(16'd1000, 16'd1000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd640, 16'd480);
		send_sprite(16'd3000, 16'd500);
		send_sprite(16'd1000, 16'd1000);
		// extreme camera with out-of-range screen sizes
		camera(16'hFFFF, 16'd0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'd0, 16'd4095);
		send_sprite(16'd0, 16'hFFFF);
		send_sprite(16'hFFFF, 16'd0);
		send_sprite(16'hFFFE, 16'd1);
		send_sprite(16'h8000, 16'h8000);
		camera(16'h8000, 16'h8000, 16'h4000, 16'd0, 16'd0, 16'h2A3D, 16'd2048, 16'd1);
		send_sprite(16'h8400, 16'h8000);
		send_sprite(16'h8001, 16'h8000);
		send_sprite(16'h7C00, 16'h8200);
		send_sprite(16'hFFFF, 16'hFFFF);
		send_sprite(16'h8000, 16'h8000);

		for (int phase = 0; phase < 10; phase++) begin
			if (phase == 3) begin
				send_idle_pct = 80;
				recv_idle_pct = 19;
			end else if (phase == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			random_camera();
			for (int i = 0; i < 85; i++) begin
				if ($urandom_range(9) < 7) begin
					// sprites within 4096 map units of the camera on each axis
					px = sb.regs[REG_CAM_POS_X] + 16'($urandom_range(8192) - 4096);
					py = sb.regs[REG_CAM_POS_Y] + 16'($urandom_range(8192) - 4096);
				end else begin
					px = 16'($urandom);
					py = 16'($urandom);
				end
				send_sprite(px, py);
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		drain();
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
